>>> hw/rtl/ce6_pkg.sv
// Shared types, operation codes and helpers for the 6502-style execute unit.
package ce6_pkg;

    // Operation codes.
    localparam logic [5:0] K_NOP = 6'd0,  K_JMP = 6'd1,  K_JSR = 6'd2,  K_RTS = 6'd3;
    localparam logic [5:0] K_RTI = 6'd4,  K_BCC = 6'd5,  K_BCS = 6'd6,  K_BEQ = 6'd7;
    localparam logic [5:0] K_BNE = 6'd8,  K_BMI = 6'd9,  K_BPL = 6'd10, K_BVS = 6'd11;
    localparam logic [5:0] K_BVC = 6'd12, K_LDA = 6'd13, K_STA = 6'd14, K_LDX = 6'd15;
    localparam logic [5:0] K_STX = 6'd16, K_LDY = 6'd17, K_STY = 6'd18, K_PHA = 6'd19;
    localparam logic [5:0] K_PHP = 6'd20, K_PLA = 6'd21, K_PLP = 6'd22, K_BIT = 6'd23;
    localparam logic [5:0] K_CMP = 6'd24, K_CPX = 6'd25, K_CPY = 6'd26, K_SEC = 6'd27;
    localparam logic [5:0] K_CLC = 6'd28, K_SED = 6'd29, K_CLD = 6'd30, K_SEI = 6'd31;
    localparam logic [5:0] K_CLI = 6'd32, K_CLV = 6'd33, K_AND = 6'd34, K_ORA = 6'd35;
    localparam logic [5:0] K_EOR = 6'd36, K_ADC = 6'd37, K_SBC = 6'd38, K_INC = 6'd39;
    localparam logic [5:0] K_INX = 6'd40, K_INY = 6'd41, K_DEC = 6'd42, K_DEX = 6'd43;
    localparam logic [5:0] K_DEY = 6'd44, K_ASL = 6'd45, K_LSR = 6'd46, K_ROL = 6'd47;
    localparam logic [5:0] K_ROR = 6'd48, K_TAX = 6'd49, K_TAY = 6'd50, K_TXA = 6'd51;
    localparam logic [5:0] K_TYA = 6'd52, K_TSX = 6'd53, K_TXS = 6'd54;

    // Status bit positions.
    localparam int FL_C = 0;
    localparam int FL_Z = 1;
    localparam int FL_I = 2;
    localparam int FL_D = 3;
    localparam int FL_V = 6;
    localparam int FL_N = 7;

    localparam logic [7:0]  P_FIXED   = 8'h30;
    localparam logic [7:0]  STK_HIGH  = 8'h01;
    localparam logic [7:0]  SP_RESET  = 8'hfd;
    localparam logic [7:0]  P_RESET   = 8'h24;
    localparam logic [15:0] PC_RESET  = 16'hc000;

    // Architectural registers.
    typedef struct packed {
        logic [7:0]  a;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  sp;
        logic [7:0]  p;
        logic [15:0] pc;
    } t_regs;

    // Up to two stack-page writes per beat.
    typedef struct packed {
        logic       we0;
        logic [7:0] a0;
        logic [7:0] d0;
        logic       we1;
        logic [7:0] a1;
        logic [7:0] d1;
    } t_stk_wr;

    // Result beat.
    typedef struct packed {
        logic        mem_write;
        logic [15:0] mem_address;
        logic [7:0]  mem_data;
        logic [15:0] next_pc;
        logic [7:0]  flags;
        logic        branch_taken;
    } t_res;

    // Update N and Z from a value.
    function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] f;
        f       = p;
        f[FL_N] = v[7];
        f[FL_Z] = (v == 8'h00);
        return f;
    endfunction

endpackage

>>> hw/rtl/ce6_stack.sv
// Stack page: four 64-byte banks with registered reads of the next three pull slots.
module ce6_stack (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_sp,
    input  logic [7:0]         i_sp_next,
    input  ce6_pkg::t_stk_wr   i_wr,
    output logic [2:0][7:0]    o_pull
);

    logic [255:0]    r_vld;
    logic [3:0][7:0] r_rd;
    logic [3:0]      r_rd_vld;
    logic [1:0]      base;

    assign base = 2'(i_sp_next + 8'd1);

    // Valid bits, one per byte; unwritten bytes read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (i_wr.we0) r_vld[i_wr.a0] <= 1'b1;
            if (i_wr.we1) r_vld[i_wr.a1] <= 1'b1;
        end
    end

    genvar b;
    generate
        for (b = 0; b < 4; b++) begin : g_bank
            logic [7:0] mem [64];
            logic       we;
            logic [5:0] widx;
            logic [7:0] wd;
            logic [7:0] raddr;
            logic       hit;

            // Bank write port: the two writes never fall in one bank.
            always_comb begin
                we   = 1'b0;
                widx = i_wr.a0[7:2];
                wd   = i_wr.d0;
                if (i_wr.we0 && (i_wr.a0[1:0] == 2'(b))) begin
                    we = 1'b1;
                end else if (i_wr.we1 && (i_wr.a1[1:0] == 2'(b))) begin
                    we   = 1'b1;
                    widx = i_wr.a1[7:2];
                    wd   = i_wr.d1;
                end
            end

            // Slot among sp+1..sp+4 that lives in this bank.
            assign raddr = i_sp_next + 8'd1 + {6'd0, 2'(2'(b) - base)};
            assign hit   = we && (widx == raddr[7:2]);

            always_ff @(posedge i_clk) begin
                if (we) mem[widx] <= wd;
                r_rd[b] <= hit ? wd : mem[raddr[7:2]];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_rd_vld[b] <= 1'b0;
                end else begin
                    r_rd_vld[b] <= hit || r_vld[raddr];
                end
            end
        end
    endgenerate

    // Pull bytes at sp+1, sp+2, sp+3.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic [1:0] bk;
            bk        = 2'(i_sp + 8'(k + 1));
            o_pull[k] = r_rd_vld[bk] ? r_rd[bk] : 8'h00;
        end
    end

endmodule

>>> hw/rtl/ce6_exec.sv
// Single-pass instruction datapath: next register state, stack writes and result beat.
module ce6_exec (
    input  logic [5:0]        i_kind,
    input  logic [7:0]        i_operand_byte,
    input  logic [15:0]       i_effective_address,
    input  logic              i_on_accumulator,
    input  logic [1:0]        i_instr_length,
    input  ce6_pkg::t_regs    i_regs,
    input  logic [2:0][7:0]   i_pull,
    output ce6_pkg::t_regs    o_regs,
    output ce6_pkg::t_stk_wr  o_wr,
    output ce6_pkg::t_res     o_res
);

    logic [7:0]  m, bop, v, r, cmp_reg;
    logic [8:0]  sum, diff;
    logic        wr, br, cond, cin;
    logic [15:0] waddr;
    logic [7:0]  wdata;
    logic [15:0] jsr_ret;
    ce6_pkg::t_regs s;

    assign m       = i_operand_byte;
    assign cin     = i_regs.p[ce6_pkg::FL_C];
    assign bop     = (i_kind == ce6_pkg::K_SBC) ? ~m : m;
    assign sum     = {1'b0, i_regs.a} + {1'b0, bop} + {8'd0, cin};
    assign jsr_ret = i_regs.pc + 16'd2;
    assign v       = i_on_accumulator ? i_regs.a : m;
    assign cmp_reg = (i_kind == ce6_pkg::K_CPX) ? i_regs.x :
                     (i_kind == ce6_pkg::K_CPY) ? i_regs.y : i_regs.a;
    assign diff    = {1'b0, cmp_reg} - {1'b0, m};

    // Shift and rotate result.
    always_comb begin
        unique case (i_kind)
            ce6_pkg::K_ASL: r = {v[6:0], 1'b0};
            ce6_pkg::K_ROL: r = {v[6:0], cin};
            ce6_pkg::K_LSR: r = {1'b0, v[7:1]};
            default:        r = {cin, v[7:1]};
        endcase
    end

    always_comb begin
        s          = i_regs;
        s.pc       = i_regs.pc + {14'd0, i_instr_length};
        wr         = 1'b0;
        waddr      = i_effective_address;
        wdata      = 8'h00;
        br         = 1'b0;
        cond       = 1'b0;
        o_wr       = '0;
        o_wr.a0    = i_regs.sp;
        o_wr.a1    = i_regs.sp - 8'd1;
        unique case (i_kind)
            ce6_pkg::K_JMP: s.pc = i_effective_address;
            ce6_pkg::K_JSR: begin
                o_wr.we0 = 1'b1;
                o_wr.d0  = jsr_ret[15:8];
                o_wr.we1 = 1'b1;
                o_wr.d1  = jsr_ret[7:0];
                s.sp     = i_regs.sp - 8'd2;
                s.pc     = i_effective_address;
            end
            ce6_pkg::K_RTS: begin
                s.sp = i_regs.sp + 8'd2;
                s.pc = {i_pull[1], i_pull[0]} + 16'd1;
            end
            ce6_pkg::K_RTI: begin
                s.sp = i_regs.sp + 8'd3;
                s.p  = (i_regs.p & ce6_pkg::P_FIXED) | (i_pull[0] & ~ce6_pkg::P_FIXED);
                s.pc = {i_pull[2], i_pull[1]};
            end
            ce6_pkg::K_BCC: begin br = 1'b1; cond = !i_regs.p[ce6_pkg::FL_C]; end
            ce6_pkg::K_BCS: begin br = 1'b1; cond = i_regs.p[ce6_pkg::FL_C]; end
            ce6_pkg::K_BEQ: begin br = 1'b1; cond = i_regs.p[ce6_pkg::FL_Z]; end
            ce6_pkg::K_BNE: begin br = 1'b1; cond = !i_regs.p[ce6_pkg::FL_Z]; end
            ce6_pkg::K_BMI: begin br = 1'b1; cond = i_regs.p[ce6_pkg::FL_N]; end
            ce6_pkg::K_BPL: begin br = 1'b1; cond = !i_regs.p[ce6_pkg::FL_N]; end
            ce6_pkg::K_BVS: begin br = 1'b1; cond = i_regs.p[ce6_pkg::FL_V]; end
            ce6_pkg::K_BVC: begin br = 1'b1; cond = !i_regs.p[ce6_pkg::FL_V]; end
            ce6_pkg::K_LDA: begin s.a = m; s.p = ce6_pkg::set_nz(i_regs.p, m); end
            ce6_pkg::K_LDX: begin s.x = m; s.p = ce6_pkg::set_nz(i_regs.p, m); end
            ce6_pkg::K_LDY: begin s.y = m; s.p = ce6_pkg::set_nz(i_regs.p, m); end
            ce6_pkg::K_STA: begin wr = 1'b1; wdata = i_regs.a; end
            ce6_pkg::K_STX: begin wr = 1'b1; wdata = i_regs.x; end
            ce6_pkg::K_STY: begin wr = 1'b1; wdata = i_regs.y; end
            ce6_pkg::K_PHA: begin
                o_wr.we0 = 1'b1;
                o_wr.d0  = i_regs.a;
                s.sp     = i_regs.sp - 8'd1;
            end
            ce6_pkg::K_PHP: begin
                o_wr.we0 = 1'b1;
                o_wr.d0  = i_regs.p | ce6_pkg::P_FIXED;
                s.sp     = i_regs.sp - 8'd1;
            end
            ce6_pkg::K_PLA: begin
                s.sp = i_regs.sp + 8'd1;
                s.a  = i_pull[0];
                s.p  = ce6_pkg::set_nz(i_regs.p, i_pull[0]);
            end
            ce6_pkg::K_PLP: begin
                s.sp = i_regs.sp + 8'd1;
                s.p  = (i_regs.p & ce6_pkg::P_FIXED) | (i_pull[0] & ~ce6_pkg::P_FIXED);
            end
            ce6_pkg::K_BIT: begin
                s.p[ce6_pkg::FL_N] = m[7];
                s.p[ce6_pkg::FL_V] = m[6];
                s.p[ce6_pkg::FL_Z] = ((m & i_regs.a) == 8'h00);
            end
            ce6_pkg::K_CMP, ce6_pkg::K_CPX, ce6_pkg::K_CPY: begin
                s.p = ce6_pkg::set_nz(i_regs.p, diff[7:0]);
                s.p[ce6_pkg::FL_C] = !diff[8];
            end
            ce6_pkg::K_SEC: s.p[ce6_pkg::FL_C] = 1'b1;
            ce6_pkg::K_CLC: s.p[ce6_pkg::FL_C] = 1'b0;
            ce6_pkg::K_SED: s.p[ce6_pkg::FL_D] = 1'b1;
            ce6_pkg::K_CLD: s.p[ce6_pkg::FL_D] = 1'b0;
            ce6_pkg::K_SEI: s.p[ce6_pkg::FL_I] = 1'b1;
            ce6_pkg::K_CLI: s.p[ce6_pkg::FL_I] = 1'b0;
            ce6_pkg::K_CLV: s.p[ce6_pkg::FL_V] = 1'b0;
            ce6_pkg::K_AND: begin
                s.a = i_regs.a & m;
                s.p = ce6_pkg::set_nz(i_regs.p, i_regs.a & m);
            end
            ce6_pkg::K_ORA: begin
                s.a = i_regs.a | m;
                s.p = ce6_pkg::set_nz(i_regs.p, i_regs.a | m);
            end
            ce6_pkg::K_EOR: begin
                s.a = i_regs.a ^ m;
                s.p = ce6_pkg::set_nz(i_regs.p, i_regs.a ^ m);
            end
            ce6_pkg::K_ADC, ce6_pkg::K_SBC: begin
                s.a = sum[7:0];
                s.p = ce6_pkg::set_nz(i_regs.p, sum[7:0]);
                s.p[ce6_pkg::FL_C] = sum[8];
                s.p[ce6_pkg::FL_V] = ((i_regs.a ^ sum[7:0]) & (bop ^ sum[7:0])) >> 7 != 8'h00;
            end
            ce6_pkg::K_INC: begin
                wr    = 1'b1;
                wdata = m + 8'd1;
                s.p   = ce6_pkg::set_nz(i_regs.p, m + 8'd1);
            end
            ce6_pkg::K_DEC: begin
                wr    = 1'b1;
                wdata = m - 8'd1;
                s.p   = ce6_pkg::set_nz(i_regs.p, m - 8'd1);
            end
            ce6_pkg::K_INX: begin
                s.x = i_regs.x + 8'd1;
                s.p = ce6_pkg::set_nz(i_regs.p, i_regs.x + 8'd1);
            end
            ce6_pkg::K_INY: begin
                s.y = i_regs.y + 8'd1;
                s.p = ce6_pkg::set_nz(i_regs.p, i_regs.y + 8'd1);
            end
            ce6_pkg::K_DEX: begin
                s.x = i_regs.x - 8'd1;
                s.p = ce6_pkg::set_nz(i_regs.p, i_regs.x - 8'd1);
            end
            ce6_pkg::K_DEY: begin
                s.y = i_regs.y - 8'd1;
                s.p = ce6_pkg::set_nz(i_regs.p, i_regs.y - 8'd1);
            end
            ce6_pkg::K_ASL, ce6_pkg::K_LSR, ce6_pkg::K_ROL, ce6_pkg::K_ROR: begin
                s.p = ce6_pkg::set_nz(i_regs.p, r);
                s.p[ce6_pkg::FL_C] = ((i_kind == ce6_pkg::K_ASL) ||
                                      (i_kind == ce6_pkg::K_ROL)) ? v[7] : v[0];
                if (i_on_accumulator) begin
                    s.a = r;
                end else begin
                    wr    = 1'b1;
                    wdata = r;
                end
            end
            ce6_pkg::K_TAX: begin s.x = i_regs.a; s.p = ce6_pkg::set_nz(i_regs.p, i_regs.a); end
            ce6_pkg::K_TAY: begin s.y = i_regs.a; s.p = ce6_pkg::set_nz(i_regs.p, i_regs.a); end
            ce6_pkg::K_TXA: begin s.a = i_regs.x; s.p = ce6_pkg::set_nz(i_regs.p, i_regs.x); end
            ce6_pkg::K_TYA: begin s.a = i_regs.y; s.p = ce6_pkg::set_nz(i_regs.p, i_regs.y); end
            ce6_pkg::K_TSX: begin s.x = i_regs.sp; s.p = ce6_pkg::set_nz(i_regs.p, i_regs.sp); end
            ce6_pkg::K_TXS: s.sp = i_regs.x;
            default: ;
        endcase

        if (br && cond) s.pc = i_effective_address;

        // External writes into page one also land in the stack page.
        if (wr && (waddr[15:8] == ce6_pkg::STK_HIGH)) begin
            o_wr.we0 = 1'b1;
            o_wr.a0  = waddr[7:0];
            o_wr.d0  = wdata;
        end
    end

    assign o_regs                = s;
    assign o_res.mem_write       = wr;
    assign o_res.mem_address     = wr ? waddr : 16'h0000;
    assign o_res.mem_data        = wr ? wdata : 8'h00;
    assign o_res.next_pc         = s.pc;
    assign o_res.flags           = s.p;
    assign o_res.branch_taken    = br && cond;

endmodule

>>> hw/rtl/cpu6502_instruction_execute_unit.sv
// Execute unit top level: register file, result register and handshakes.
// The result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one instruction per cycle while the receiver does not stall; the stack page
// banks are read into registers ahead, at the next stack pointer, so pulls cost nothing extra.
// Reset (synchronous, active low): A/X/Y = 0, S = 0xfd, P = 0x24, PC = 0xc000,
// stack page reads as zero via per-byte valid bits cleared at once.
module cpu6502_instruction_execute_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [5:0]  i_kind,
    input  logic [7:0]  i_operand_byte,
    input  logic [15:0] i_effective_address,
    input  logic        i_on_accumulator,
    input  logic [1:0]  i_instr_length,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_mem_write,
    output logic [15:0] o_mem_address,
    output logic [7:0]  o_mem_data,
    output logic [15:0] o_next_pc,
    output logic [7:0]  o_flags,
    output logic        o_branch_taken
);

    ce6_pkg::t_regs   r_regs, n_regs, x_regs;
    ce6_pkg::t_stk_wr x_wr, n_wr;
    ce6_pkg::t_res    r_res, x_res;
    logic             r_out_valid;
    logic             in_acc;
    logic [2:0][7:0]  pull;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    ce6_exec u_exec (
        .i_kind              (i_kind),
        .i_operand_byte      (i_operand_byte),
        .i_effective_address (i_effective_address),
        .i_on_accumulator    (i_on_accumulator),
        .i_instr_length      (i_instr_length),
        .i_regs              (r_regs),
        .i_pull              (pull),
        .o_regs              (x_regs),
        .o_wr                (x_wr),
        .o_res               (x_res)
    );

    // Commit only on an accepted beat.
    always_comb begin
        n_regs = in_acc ? x_regs : r_regs;
        n_wr   = x_wr;
        if (!in_acc) begin
            n_wr.we0 = 1'b0;
            n_wr.we1 = 1'b0;
        end
    end

    ce6_stack u_stack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sp      (r_regs.sp),
        .i_sp_next (n_regs.sp),
        .i_wr      (n_wr),
        .o_pull    (pull)
    );

    // Architectural registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs.a  <= 8'h00;
            r_regs.x  <= 8'h00;
            r_regs.y  <= 8'h00;
            r_regs.sp <= ce6_pkg::SP_RESET;
            r_regs.p  <= ce6_pkg::P_RESET;
            r_regs.pc <= ce6_pkg::PC_RESET;
        end else begin
            r_regs <= n_regs;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) r_res <= x_res;
    end

    assign o_out_valid    = r_out_valid;
    assign o_mem_write    = r_res.mem_write;
    assign o_mem_address  = r_res.mem_address;
    assign o_mem_data     = r_res.mem_data;
    assign o_next_pc      = r_res.next_pc;
    assign o_flags        = r_res.flags;
    assign o_branch_taken = r_res.branch_taken;

`ifndef SYNTHESIS
    a_acc_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_out_valid) else $error("accepted beat produced no result");
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_out_valid) else $error("input stalled with empty result register");
    a_nowrite_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_mem_write) |-> (o_mem_address == 16'h0000 && o_mem_data == 8'h00))
        else $error("write fields not cleared");
    a_pc_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_regs.pc == o_next_pc)) else $error("PC and result disagree");
`endif

endmodule

>>> tb/tb.sv
// Self-checking bench for the 6502-style execute unit: directed table, then random programs.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_CYCLES = 20000;
    localparam int N_RANDOM        = 375;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [5:0]  i_kind;
    logic [7:0]  i_operand_byte;
    logic [15:0] i_effective_address;
    logic        i_on_accumulator;
    logic [1:0]  i_instr_length;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_mem_write;
    logic [15:0] o_mem_address;
    logic [7:0]  o_mem_data;
    logic [15:0] o_next_pc;
    logic [7:0]  o_flags;
    logic        o_branch_taken;

    cpu6502_instruction_execute_unit u_dut (.*);

    // One decoded instruction.
    typedef struct {
        logic [5:0]  kind;
        logic [7:0]  opnd;
        logic [15:0] ea;
        logic        on_acc;
        logic [1:0]  len;
    } t_instr;

    // Directed row: instruction plus optional typed-in result.
    typedef struct {
        t_instr         ins;
        bit             fixed;
        ce6_pkg::t_res  res;
    } t_row;

    // Shadow architectural state.
    logic [7:0]  sh_a, sh_x, sh_y, sh_sp, sh_p;
    logic [15:0] sh_pc;
    logic [7:0]  sh_stack [256];

    ce6_pkg::t_res exec_queue[$];
    t_row          row_queue[$];
    int     fail_count;
    int     idle_cycles;
    bit     calm_phase;
    bit     hold_request;
    int     hold_left;
    int     out_gap;

    // Clock.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void push_stack(input logic [7:0] v);
        sh_stack[sh_sp] = v;
        sh_sp = sh_sp - 8'd1;
    endfunction

    function automatic logic [7:0] pull_stack();
        sh_sp = sh_sp + 8'd1;
        return sh_stack[sh_sp];
    endfunction

    function automatic logic [7:0] with_nz(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] f;
        f = p;
        f[ce6_pkg::FL_N] = v[7];
        f[ce6_pkg::FL_Z] = (v == 8'h00);
        return f;
    endfunction

    // Execute one instruction on the shadow state and return the expected beat.
    function automatic ce6_pkg::t_res execute_instr(input t_instr ins);
        ce6_pkg::t_res r;
        logic [15:0] npc, w;
        logic        cond, is_br;
        logic [7:0]  b, v, q, ov;
        logic [8:0]  sum;
        logic        cin;
        r = '0;
        npc = sh_pc + 16'(ins.len);
        cond = 1'b0;
        is_br = 1'b0;
        cin = sh_p[ce6_pkg::FL_C];
        case (ins.kind)
            ce6_pkg::K_JMP: npc = ins.ea;
            ce6_pkg::K_JSR: begin
                w = sh_pc + 16'd2;
                push_stack(w[15:8]);
                push_stack(w[7:0]);
                npc = ins.ea;
            end
            ce6_pkg::K_RTS: begin
                w[7:0] = pull_stack();
                w[15:8] = pull_stack();
                npc = w + 16'd1;
            end
            ce6_pkg::K_RTI: begin
                sh_p = (sh_p & ce6_pkg::P_FIXED) | (pull_stack() & ~ce6_pkg::P_FIXED);
                npc[7:0] = pull_stack();
                npc[15:8] = pull_stack();
            end
            ce6_pkg::K_BCC: begin is_br = 1'b1; cond = !sh_p[ce6_pkg::FL_C]; end
            ce6_pkg::K_BCS: begin is_br = 1'b1; cond = sh_p[ce6_pkg::FL_C]; end
            ce6_pkg::K_BEQ: begin is_br = 1'b1; cond = sh_p[ce6_pkg::FL_Z]; end
            ce6_pkg::K_BNE: begin is_br = 1'b1; cond = !sh_p[ce6_pkg::FL_Z]; end
            ce6_pkg::K_BMI: begin is_br = 1'b1; cond = sh_p[ce6_pkg::FL_N]; end
            ce6_pkg::K_BPL: begin is_br = 1'b1; cond = !sh_p[ce6_pkg::FL_N]; end
            ce6_pkg::K_BVS: begin is_br = 1'b1; cond = sh_p[ce6_pkg::FL_V]; end
            ce6_pkg::K_BVC: begin is_br = 1'b1; cond = !sh_p[ce6_pkg::FL_V]; end
            ce6_pkg::K_LDA: begin sh_a = ins.opnd; sh_p = with_nz(sh_p, sh_a); end
            ce6_pkg::K_LDX: begin sh_x = ins.opnd; sh_p = with_nz(sh_p, sh_x); end
            ce6_pkg::K_LDY: begin sh_y = ins.opnd; sh_p = with_nz(sh_p, sh_y); end
            ce6_pkg::K_STA: begin
                r.mem_write = 1'b1; r.mem_address = ins.ea; r.mem_data = sh_a;
            end
            ce6_pkg::K_STX: begin
                r.mem_write = 1'b1; r.mem_address = ins.ea; r.mem_data = sh_x;
            end
            ce6_pkg::K_STY: begin
                r.mem_write = 1'b1; r.mem_address = ins.ea; r.mem_data = sh_y;
            end
            ce6_pkg::K_PHA: push_stack(sh_a);
            ce6_pkg::K_PHP: push_stack(sh_p | ce6_pkg::P_FIXED);
            ce6_pkg::K_PLA: begin sh_a = pull_stack(); sh_p = with_nz(sh_p, sh_a); end
            ce6_pkg::K_PLP:
                sh_p = (sh_p & ce6_pkg::P_FIXED) | (pull_stack() & ~ce6_pkg::P_FIXED);
            ce6_pkg::K_BIT: begin
                sh_p[ce6_pkg::FL_N] = ins.opnd[7];
                sh_p[ce6_pkg::FL_V] = ins.opnd[6];
                sh_p[ce6_pkg::FL_Z] = ((ins.opnd & sh_a) == 8'h00);
            end
            ce6_pkg::K_CMP, ce6_pkg::K_CPX, ce6_pkg::K_CPY: begin
                v = (ins.kind == ce6_pkg::K_CMP) ? sh_a :
                    (ins.kind == ce6_pkg::K_CPX) ? sh_x : sh_y;
                sh_p = with_nz(sh_p, v - ins.opnd);
                sh_p[ce6_pkg::FL_C] = (v >= ins.opnd);
            end
            ce6_pkg::K_SEC: sh_p[ce6_pkg::FL_C] = 1'b1;
            ce6_pkg::K_CLC: sh_p[ce6_pkg::FL_C] = 1'b0;
            ce6_pkg::K_SED: sh_p[ce6_pkg::FL_D] = 1'b1;
            ce6_pkg::K_CLD: sh_p[ce6_pkg::FL_D] = 1'b0;
            ce6_pkg::K_SEI: sh_p[ce6_pkg::FL_I] = 1'b1;
            ce6_pkg::K_CLI: sh_p[ce6_pkg::FL_I] = 1'b0;
            ce6_pkg::K_CLV: sh_p[ce6_pkg::FL_V] = 1'b0;
            ce6_pkg::K_AND: begin sh_a = sh_a & ins.opnd; sh_p = with_nz(sh_p, sh_a); end
            ce6_pkg::K_ORA: begin sh_a = sh_a | ins.opnd; sh_p = with_nz(sh_p, sh_a); end
            ce6_pkg::K_EOR: begin sh_a = sh_a ^ ins.opnd; sh_p = with_nz(sh_p, sh_a); end
            ce6_pkg::K_ADC, ce6_pkg::K_SBC: begin
                b = (ins.kind == ce6_pkg::K_SBC) ? ~ins.opnd : ins.opnd;
                sum = {1'b0, sh_a} + {1'b0, b} + 9'(cin);
                q = sum[7:0];
                ov = (sh_a ^ q) & (b ^ q);
                sh_p[ce6_pkg::FL_V] = ov[7];
                sh_p[ce6_pkg::FL_C] = sum[8];
                sh_a = q;
                sh_p = with_nz(sh_p, sh_a);
            end
            ce6_pkg::K_INC, ce6_pkg::K_DEC: begin
                r.mem_data = (ins.kind == ce6_pkg::K_INC) ? ins.opnd + 8'd1 : ins.opnd - 8'd1;
                r.mem_write = 1'b1;
                r.mem_address = ins.ea;
                sh_p = with_nz(sh_p, r.mem_data);
            end
            ce6_pkg::K_INX: begin sh_x = sh_x + 8'd1; sh_p = with_nz(sh_p, sh_x); end
            ce6_pkg::K_INY: begin sh_y = sh_y + 8'd1; sh_p = with_nz(sh_p, sh_y); end
            ce6_pkg::K_DEX: begin sh_x = sh_x - 8'd1; sh_p = with_nz(sh_p, sh_x); end
            ce6_pkg::K_DEY: begin sh_y = sh_y - 8'd1; sh_p = with_nz(sh_p, sh_y); end
            ce6_pkg::K_ASL, ce6_pkg::K_LSR, ce6_pkg::K_ROL, ce6_pkg::K_ROR: begin
                v = ins.on_acc ? sh_a : ins.opnd;
                if (ins.kind == ce6_pkg::K_ASL || ins.kind == ce6_pkg::K_ROL) begin
                    sh_p[ce6_pkg::FL_C] = v[7];
                    q = {v[6:0], (ins.kind == ce6_pkg::K_ROL) ? cin : 1'b0};
                end else begin
                    sh_p[ce6_pkg::FL_C] = v[0];
                    q = {(ins.kind == ce6_pkg::K_ROR) ? cin : 1'b0, v[7:1]};
                end
                sh_p = with_nz(sh_p, q);
                if (ins.on_acc) begin
                    sh_a = q;
                end else begin
                    r.mem_write = 1'b1;
                    r.mem_address = ins.ea;
                    r.mem_data = q;
                end
            end
            ce6_pkg::K_TAX: begin sh_x = sh_a; sh_p = with_nz(sh_p, sh_x); end
            ce6_pkg::K_TAY: begin sh_y = sh_a; sh_p = with_nz(sh_p, sh_y); end
            ce6_pkg::K_TXA: begin sh_a = sh_x; sh_p = with_nz(sh_p, sh_a); end
            ce6_pkg::K_TYA: begin sh_a = sh_y; sh_p = with_nz(sh_p, sh_a); end
            ce6_pkg::K_TSX: begin sh_x = sh_sp; sh_p = with_nz(sh_p, sh_x); end
            ce6_pkg::K_TXS: sh_sp = sh_x;
            default: ;
        endcase
        if (is_br && cond) begin
            npc = ins.ea;
            r.branch_taken = 1'b1;
        end
        // External writes into page one land in the stack too
        if (r.mem_write && r.mem_address[15:8] == ce6_pkg::STK_HIGH)
            sh_stack[r.mem_address[7:0]] = r.mem_data;
        sh_pc = npc;
        r.next_pc = npc;
        r.flags = sh_p;
        return r;
    endfunction

    function automatic t_instr mk(input logic [5:0] k, input logic [7:0] m,
                                  input logic [15:0] ea, input logic acc,
                                  input logic [1:0] len);
        t_instr t;
        t.kind = k; t.opnd = m; t.ea = ea; t.on_acc = acc; t.len = len;
        return t;
    endfunction

    function automatic ce6_pkg::t_res mkres(input logic w, input logic [15:0] addr,
                                            input logic [7:0] d, input logic [15:0] pc,
                                            input logic [7:0] f, input logic tk);
        ce6_pkg::t_res r;
        r.mem_write = w; r.mem_address = addr; r.mem_data = d;
        r.next_pc = pc; r.flags = f; r.branch_taken = tk;
        return r;
    endfunction

    // Random instruction: mostly real opcodes, some unused codes, weighted operands.
    function automatic t_instr rand_instr();
        t_instr t;
        int     sel;
        sel = $urandom_range(0, 99);
        t.kind = (sel < 4) ? 6'($urandom_range(55, 63)) : 6'($urandom_range(0, 54));
        case ($urandom_range(0, 5))
            0: t.opnd = 8'h00;
            1: t.opnd = 8'hff;
            2: t.opnd = 8'h80;
            default: t.opnd = 8'($urandom);
        endcase
        sel = $urandom_range(0, 9);
        if (sel < 2)
            t.ea = {ce6_pkg::STK_HIGH, 8'($urandom)};
        else
            t.ea = 16'($urandom);
        t.on_acc = 1'($urandom);
        t.len = 2'($urandom_range(0, 3));
        return t;
    endfunction

    // Drive one beat and wait for acceptance; without keep_valid, valid drops for a cycle.
    task automatic send_beat(input t_instr ins, input bit keep_valid);
        i_kind              <= ins.kind;
        i_operand_byte      <= ins.opnd;
        i_effective_address <= ins.ea;
        i_on_accumulator    <= ins.on_acc;
        i_instr_length      <= ins.len;
        i_in_valid          <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        if (!keep_valid) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    task automatic send_gap();
        int n;
        if (!calm_phase && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 15);
            repeat (n) @(negedge i_clk);
        end
    endtask

    // Predict on acceptance; typed-in rows supply their own expected beat.
    always @(posedge i_clk) begin
        t_row          cur;
        ce6_pkg::t_res pred;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            cur  = row_queue.pop_front();
            pred = execute_instr(cur.ins);
            exec_queue.push_back(cur.fixed ? cur.res : pred);
        end
    end

    // Result check.
    always @(posedge i_clk) begin
        ce6_pkg::t_res exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (exec_queue.size() == 0) begin
                $error("unexpected result beat, next_pc=%h", o_next_pc);
                fail_count++;
            end else begin
                exp_r = exec_queue.pop_front();
                if (o_mem_write !== exp_r.mem_write) begin
                    $error("mem_write exp %b got %b", exp_r.mem_write, o_mem_write);
                    fail_count++;
                end
                if (o_mem_address !== exp_r.mem_address) begin
                    $error("mem_address exp %h got %h", exp_r.mem_address, o_mem_address);
                    fail_count++;
                end
                if (o_mem_data !== exp_r.mem_data) begin
                    $error("mem_data exp %h got %h", exp_r.mem_data, o_mem_data);
                    fail_count++;
                end
                if (o_next_pc !== exp_r.next_pc) begin
                    $error("next_pc exp %h got %h", exp_r.next_pc, o_next_pc);
                    fail_count++;
                end
                if (o_flags !== exp_r.flags) begin
                    $error("flags exp %h got %h", exp_r.flags, o_flags);
                    fail_count++;
                end
                if (o_branch_taken !== exp_r.branch_taken) begin
                    $error("branch_taken exp %b got %b", exp_r.branch_taken, o_branch_taken);
                    fail_count++;
                end
            end
        end
    end

    // Receiver stall: random bursts, plus one long hold on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_gap = 0;
            hold_left = 0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 60;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= (hold_left > 0);
        end else if (out_gap > 0) begin
            out_gap--;
            i_out_stall <= (out_gap > 0);
        end else if (!calm_phase && $urandom_range(0, 6) == 0) begin
            out_gap = $urandom_range(1, 15);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic issue(input t_instr ins, input bit keep_valid);
        t_row rw;
        rw.ins   = ins;
        rw.fixed = 1'b0;
        rw.res   = '0;
        row_queue.push_back(rw);
        send_beat(ins, keep_valid);
    endtask

    // Wait for the queue of expected results to drain.
    task automatic drain();
        while (exec_queue.size() != 0 || row_queue.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        t_row   rows[$];
        t_row   row;
        t_instr ins;
        int     sp_mark;
        fail_count = 0;
        idle_cycles = 0;
        calm_phase = 0;
        hold_request = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_kind = ce6_pkg::K_NOP;
        i_operand_byte = '0;
        i_effective_address = '0;
        i_on_accumulator = 1'b0;
        i_instr_length = 2'd1;
        sh_a = 0; sh_x = 0; sh_y = 0;
        sh_sp = ce6_pkg::SP_RESET; sh_p = ce6_pkg::P_RESET; sh_pc = ce6_pkg::PC_RESET;
        foreach (sh_stack[i]) sh_stack[i] = 8'h00;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table; typed-in results where obvious from reset state.
        rows.push_back('{mk(ce6_pkg::K_NOP, 8'h00, 16'h0000, 1'b0, 2'd1), 1'b1,
                         mkres(1'b0, 16'h0000, 8'h00, 16'hc001, 8'h24, 1'b0)});
        rows.push_back('{mk(ce6_pkg::K_LDA, 8'h00, 16'hffff, 1'b1, 2'd2), 1'b1,
                         mkres(1'b0, 16'h0000, 8'h00, 16'hc003, 8'h26, 1'b0)});
        rows.push_back('{mk(ce6_pkg::K_STA, 8'hff, 16'hffff, 1'b0, 2'd3), 1'b1,
                         mkres(1'b1, 16'hffff, 8'h00, 16'hc006, 8'h26, 1'b0)});
        rows.push_back('{mk(ce6_pkg::K_LDX, 8'hff, 16'h0000, 1'b0, 2'd0), 1'b1,
                         mkres(1'b0, 16'h0000, 8'h00, 16'hc006, 8'ha4, 1'b0)});
        rows.push_back('{mk(ce6_pkg::K_BMI, 8'h00, 16'h1234, 1'b0, 2'd2), 1'b1,
                         mkres(1'b0, 16'h0000, 8'h00, 16'h1234, 8'ha4, 1'b1)});
        rows.push_back('{mk(ce6_pkg::K_BPL, 8'h00, 16'h5678, 1'b0, 2'd2), 1'b1,
                         mkres(1'b0, 16'h0000, 8'h00, 16'h1236, 8'ha4, 1'b0)});
        rows.push_back('{mk(6'd63, 8'hff, 16'hffff, 1'b1, 2'd1), 1'b1,
                         mkres(1'b0, 16'h0000, 8'h00, 16'h1237, 8'ha4, 1'b0)});
        rows.push_back('{mk(ce6_pkg::K_JSR, 8'h00, 16'h8000, 1'b0, 2'd3), 1'b0, '0});
        rows.push_back('{mk(ce6_pkg::K_RTS, 8'h00, 16'h0000, 1'b0, 2'd1), 1'b0, '0});
        rows.push_back('{mk(ce6_pkg::K_PHP, 8'h00, 16'h0000, 1'b0, 2'd1), 1'b0, '0});
        rows.push_back('{mk(ce6_pkg::K_SEC, 8'h00, 16'h0000, 1'b0, 2'd1), 1'b0, '0});
        rows.push_back('{mk(ce6_pkg::K_LDA, 8'h7f, 16'h0000, 1'b0, 2'd2), 1'b0, '0});
        rows.push_back('{mk(ce6_pkg::K_ADC, 8'h7f, 16'h0000, 1'b0, 2'd2), 1'b0, '0});
        rows.push_back('{mk(ce6_pkg::K_SBC, 8'h01, 16'h0000, 1'b0, 2'd2), 1'b0, '0});
        rows.push_back('{mk(ce6_pkg::K_PLP, 8'h00, 16'h0000, 1'b0, 2'd1), 1'b0, '0});
        rows.push_back('{mk(ce6_pkg::K_STA, 8'h00, 16'h01fe, 1'b0, 2'd3), 1'b0, '0});
        rows.push_back('{mk(ce6_pkg::K_PLA, 8'h00, 16'h0000, 1'b0, 2'd1), 1'b0, '0});
        rows.push_back('{mk(ce6_pkg::K_ROR, 8'h01, 16'h0120, 1'b0, 2'd2), 1'b0, '0});
        rows.push_back('{mk(ce6_pkg::K_ROL, 8'h80, 16'h0000, 1'b1, 2'd1), 1'b0, '0});
        rows.push_back('{mk(ce6_pkg::K_PHA, 8'h00, 16'h0000, 1'b0, 2'd1), 1'b0, '0});
        rows.push_back('{mk(ce6_pkg::K_PHP, 8'h00, 16'h0000, 1'b0, 2'd1), 1'b0, '0});
        rows.push_back('{mk(ce6_pkg::K_RTI, 8'h00, 16'h0000, 1'b0, 2'd1), 1'b0, '0});
        rows.push_back('{mk(ce6_pkg::K_BIT, 8'hc0, 16'h0000, 1'b0, 2'd2), 1'b0, '0});
        rows.push_back('{mk(ce6_pkg::K_TSX, 8'h00, 16'h0000, 1'b0, 2'd1), 1'b0, '0});
        rows.push_back('{mk(ce6_pkg::K_TXS, 8'h00, 16'h0000, 1'b0, 2'd1), 1'b0, '0});

        // Walk the table; typed-in rows are checked against their own result.
        foreach (rows[i]) begin
            row = rows[i];
            row_queue.push_back(row);
            send_beat(row.ins, 1'b0);
            send_gap();
        end
        drain();

        // Every opcode at least once with random content.
        for (int k = 0; k <= 54; k++) begin
            ins = rand_instr();
            ins.kind = 6'(k);
            issue(ins, 1'b0);
            send_gap();
        end

        // Long receiver hold while the sender keeps offering beats.
        hold_request = 1'b1;
        for (int n = 0; n < 20; n++)
            issue(rand_instr(), (n != 19));
        // Sender pauses until all results are in
        drain();

        // Random programs: call/return and push/pull pairs wrapped round random bodies.
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n > N_RANDOM - 80)
                calm_phase = 1;
            ins = rand_instr();
            if ($urandom_range(0, 9) == 0) begin
                sp_mark = $urandom_range(0, 1);
                issue(mk(sp_mark ? ce6_pkg::K_JSR : ce6_pkg::K_PHA, 8'($urandom),
                         16'($urandom), 1'b0, 2'd3), calm_phase);
                issue(ins, calm_phase);
                issue(mk(sp_mark ? ce6_pkg::K_RTS : ce6_pkg::K_PLA, 8'($urandom),
                         16'($urandom), 1'b0, 2'd1), calm_phase);
            end else begin
                issue(ins, calm_phase);
            end
            send_gap();
        end
        i_in_valid <= 1'b0;

        drain();
        repeat (5) @(posedge i_clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
